// ----- hdl/sync_length_crc_deframer_assert.svh -----
// Assertion macros for the sync/length/CRC deframer checker.
// No dependencies; assumes signals clk and rst exist where used.
`ifndef SYNC_LENGTH_CRC_DEFRAMER_ASSERT_SVH
`define SYNC_LENGTH_CRC_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SLCD_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, disabled while in reset
`define SLCD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- hdl/slcd_pkg.sv -----
// Shared constants for the sync/length/CRC deframer.
// No dependencies; used by slcd_crc16, sync_length_crc_deframer, slcd_checker and the testbench.
`default_nettype none

package slcd_pkg;

  // sync pair
  localparam logic [7:0] SYNC_FIRST  = 8'hA5;
  localparam logic [7:0] SYNC_SECOND = 8'h5A;

  // frame layout: total length L+27, CRC ends at L+23
  localparam int FRAME_OVERHEAD = 27;
  localparam int CRC_TRAILER    = 5;
  localparam logic [16:0] CRC_END_ADD  = 17'(FRAME_OVERHEAD - CRC_TRAILER + 1);
  localparam logic [16:0] LAST_OFS_ADD = 17'(FRAME_OVERHEAD - 1);

  // Modbus CRC-16, reflected
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

endpackage

`default_nettype wire

// ----- hdl/sync_length_crc_deframer.sv -----
// Sync-word deframer: hunts for A5 5A, reads a 16-bit length, checks a CRC-16.
// Depends on slcd_pkg and slcd_crc16.
//
// Each accepted byte's result, if any, lands in a single output register in the
// next cycle; a new byte is accepted every cycle
// as long as the output register is empty or being drained (s_tready = !m_tvalid
// || m_tready), so sustained rate is one byte per clock. The byte-wide CRC
// update and the 17-bit offset compares sit between the state registers and
// the output register. Frame bytes come out with tuser[0] on a first sync
// byte, tlast on the final byte or on an aborted sync, and tuser[1] on a final
// byte whose received CRC matched. Bytes outside a frame are dropped.
`default_nettype none

module sync_length_crc_deframer
  import slcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // input stream
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
  // output stream
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] frame_byte
  output logic            m_tlast,   // frame_last
  output logic [1:0]      m_tuser    // [0] frame_first, [1] frame_good
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_SYNC,
    PH_BODY
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] payload_length, payload_length_next;
  logic [16:0] byte_count, byte_count_next;
  logic [15:0] crc_acc, crc_acc_next;
  logic        crc_mismatch, crc_mismatch_next;

  logic        res_valid, res_first, res_last, res_good;
  logic        accept;
  logic [15:0] crc_upd;
  logic [15:0] len_cur;
  logic [16:0] crc_end, total_last;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // byte-wide CRC step
  slcd_crc16 u_crc (
    .crc_in  (crc_acc),
    .data    (s_tdata),
    .crc_out (crc_upd)
  );

  // length as it stands after this byte, and the offsets that follow from it
  always_comb begin
    if (byte_count == 17'd2) begin
      len_cur = {8'h00, s_tdata};
    end else if (byte_count == 17'd3) begin
      len_cur = {s_tdata, payload_length[7:0]};
    end else begin
      len_cur = payload_length;
    end
    crc_end    = {1'b0, len_cur} + CRC_END_ADD;
    total_last = {1'b0, len_cur} + LAST_OFS_ADD;
  end

  // framing decisions for the byte on the input
  always_comb begin
    phase_next          = phase;
    payload_length_next = payload_length;
    byte_count_next     = byte_count;
    crc_acc_next        = crc_acc;
    crc_mismatch_next   = crc_mismatch;
    res_valid           = 1'b0;
    res_first           = 1'b0;
    res_last            = 1'b0;
    res_good            = 1'b0;
    unique case (phase)
      PH_SYNC: begin
        res_valid = 1'b1;
        if (s_tdata == SYNC_SECOND) begin
          phase_next      = PH_BODY;
          byte_count_next = 17'd2;
        end else if (s_tdata == SYNC_FIRST) begin
          // restart on a repeated first sync byte
          phase_next          = PH_SYNC;
          payload_length_next = 16'd0;
          byte_count_next     = 17'd1;
          crc_acc_next        = CRC_INIT;
          crc_mismatch_next   = 1'b0;
          res_first           = 1'b1;
        end else begin
          // abort the tentative frame
          phase_next          = PH_HUNT;
          payload_length_next = 16'd0;
          byte_count_next     = 17'd0;
          crc_acc_next        = CRC_INIT;
          crc_mismatch_next   = 1'b0;
          res_last            = 1'b1;
        end
      end
      PH_BODY: begin
        res_valid           = 1'b1;
        payload_length_next = len_cur;
        // CRC over the length and body bytes, then compare the two trailer bytes
        if (byte_count <= 17'd3 || byte_count <= crc_end) begin
          crc_acc_next = crc_upd;
        end else if (byte_count == crc_end + 17'd1) begin
          if (s_tdata != crc_acc[7:0]) crc_mismatch_next = 1'b1;
        end else if (byte_count == crc_end + 17'd2) begin
          if (s_tdata != crc_acc[15:8]) crc_mismatch_next = 1'b1;
        end
        if (byte_count >= 17'd4 && byte_count >= total_last) begin
          res_last            = 1'b1;
          res_good            = !crc_mismatch_next;
          phase_next          = PH_HUNT;
          payload_length_next = 16'd0;
          byte_count_next     = 17'd0;
          crc_acc_next        = CRC_INIT;
          crc_mismatch_next   = 1'b0;
        end else begin
          byte_count_next = byte_count + 17'd1;
        end
      end
      default: begin
        // hunting
        if (s_tdata == SYNC_FIRST) begin
          res_valid           = 1'b1;
          res_first           = 1'b1;
          phase_next          = PH_SYNC;
          payload_length_next = 16'd0;
          byte_count_next     = 17'd1;
          crc_acc_next        = CRC_INIT;
          crc_mismatch_next   = 1'b0;
        end else begin
          phase_next = PH_HUNT;
        end
      end
    endcase
  end

  // framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      payload_length <= 16'd0;
      byte_count     <= 17'd0;
      crc_acc        <= CRC_INIT;
      crc_mismatch   <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      payload_length <= payload_length_next;
      byte_count     <= byte_count_next;
      crc_acc        <= crc_acc_next;
      crc_mismatch   <= crc_mismatch_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      m_tdata <= s_tdata;
      m_tlast <= res_last;
      m_tuser <= {res_good, res_first};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/slcd_crc16.sv -----
// Byte-wide Modbus CRC-16 update (eight reflected shift steps).
// Depends on slcd_pkg for the polynomial.
`default_nettype none

module slcd_crc16
  import slcd_pkg::*;
(
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data,
  output logic      [15:0] crc_out
);

  // fold the byte in, then shift out eight bits
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

// ----- hdl/slcd_checker.sv -----
// Port-level checker for sync_length_crc_deframer, bound to the top level.
// Depends on sync_length_crc_deframer_assert.svh for the assertion macros and slcd_pkg.
`default_nettype none

`include "sync_length_crc_deframer_assert.svh"

module slcd_checker
  import slcd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic [7:0] s_tdata,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic [1:0] m_tuser
);

  // a stalled result transfer holds
  `SLCD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled output changed")

  // good flag only on a final byte
  `SLCD_ASSERT_NOW(a_good_last, m_tvalid && m_tuser[1], m_tlast, "frame_good without frame_last")

  // a first byte never closes a frame, and it is always the first sync byte
  `SLCD_ASSERT_NOW(a_first, m_tvalid && m_tuser[0], !m_tlast && m_tdata == SYNC_FIRST, "bad first byte")

  // input backpressure only while a result is stuck
  `SLCD_ASSERT_NOW(a_ready, !s_tready, m_tvalid && !m_tready, "input stalled without cause")

endmodule

bind sync_length_crc_deframer slcd_checker u_slcd_checker (.*);

`default_nettype wire

// ----- sim/sync_length_crc_deframer_tb.sv -----
// Self-checking testbench for sync_length_crc_deframer: byte stream in, framed bytes out.
// Depends on slcd_pkg and the deframer RTL; a scoreboard class predicts every transfer.
`timescale 1ns / 1ps

import slcd_pkg::*;

typedef enum logic [1:0] {DF_HUNT, DF_SYNC, DF_BODY} deframe_state_t;

typedef enum int {CRC_INTACT, CRC_BAD_LOW, CRC_BAD_HIGH, CRC_BAD_BOTH} crc_fault_t;

typedef struct packed {
  logic [7:0] data;
  logic       first;
  logic       last;
  logic       good;
} frame_beat_t;

// one byte through the reflected Modbus CRC-16
function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
  logic [15:0] c;
  c = crc ^ {8'h00, b};
  for (int k = 0; k < 8; k++) begin
    if (c[0]) c = (c >> 1) ^ CRC_POLY;
    else c = c >> 1;
  end
  return c;
endfunction

class deframe_scoreboard;
  deframe_state_t state;
  logic [15:0]    frame_len;
  logic [16:0]    offset;
  logic [15:0]    crc;
  bit             crc_bad;
  frame_beat_t    beats_q[$];
  int             errors;

  function new();
    go_hunt();
    errors = 0;
  endfunction

  function void go_hunt();
    state = DF_HUNT;
    frame_len = '0;
    offset = '0;
    crc = CRC_INIT;
    crc_bad = 1'b0;
  endfunction

  function void start_frame();
    state = DF_SYNC;
    frame_len = '0;
    offset = 17'd1;
    crc = CRC_INIT;
    crc_bad = 1'b0;
  endfunction

  function void push_beat(logic [7:0] d, logic first, logic last, logic good);
    frame_beat_t bt;
    bt.data = d;
    bt.first = first;
    bt.last = last;
    bt.good = good;
    beats_q.push_back(bt);
  endfunction

  // accepted input byte: advance the predicted deframer by one step
  function void note_byte(logic [7:0] b);
    logic [16:0] crc_end;
    logic [16:0] last_ofs;
    case (state)
      DF_SYNC: begin
        if (b == SYNC_SECOND) begin
          state = DF_BODY;
          offset = 17'd2;
          push_beat(b, 1'b0, 1'b0, 1'b0);
        end else if (b == SYNC_FIRST) begin
          start_frame();
          push_beat(b, 1'b1, 1'b0, 1'b0);
        end else begin
          // tentative frame aborted
          go_hunt();
          push_beat(b, 1'b0, 1'b1, 1'b0);
        end
      end
      DF_BODY: begin
        if (offset == 17'd2) frame_len = {8'h00, b};
        else if (offset == 17'd3) frame_len = {b, frame_len[7:0]};
        crc_end = {1'b0, frame_len} + CRC_END_ADD;
        last_ofs = {1'b0, frame_len} + LAST_OFS_ADD;
        if (offset <= crc_end) crc = crc16_step(crc, b);
        else if (offset == crc_end + 17'd1) begin
          if (b != crc[7:0]) crc_bad = 1'b1;
        end else if (offset == crc_end + 17'd2) begin
          if (b != crc[15:8]) crc_bad = 1'b1;
        end
        if (offset >= 17'd4 && offset >= last_ofs) begin
          push_beat(b, 1'b0, 1'b1, !crc_bad);
          go_hunt();
        end else begin
          offset = offset + 17'd1;
          push_beat(b, 1'b0, 1'b0, 1'b0);
        end
      end
      default: begin
        if (b == SYNC_FIRST) begin
          start_frame();
          push_beat(b, 1'b1, 1'b0, 1'b0);
        end
      end
    endcase
  endfunction

  // accepted output transfer: compare with the oldest predicted beat
  function void check_beat(logic [7:0] d, logic last, logic [1:0] user);
    frame_beat_t bt;
    if (beats_q.size() == 0) begin
      errors++;
      if (errors < 40)
        $display("%0t: unexpected output transfer data=%h last=%b user=%b", $time, d, last, user);
      return;
    end
    bt = beats_q.pop_front();
    if (d !== bt.data || user[0] !== bt.first || last !== bt.last || user[1] !== bt.good) begin
      errors++;
      if (errors < 40) begin
        if (d !== bt.data)
          $display("%0t: frame_byte expected %h actual %h", $time, bt.data, d);
        if (user[0] !== bt.first)
          $display("%0t: frame_first expected %b actual %b", $time, bt.first, user[0]);
        if (last !== bt.last)
          $display("%0t: frame_last expected %b actual %b", $time, bt.last, last);
        if (user[1] !== bt.good)
          $display("%0t: frame_good expected %b actual %b", $time, bt.good, user[1]);
      end
    end
  endfunction

  function int pending();
    return beats_q.size();
  endfunction
endclass

module sync_length_crc_deframer_tb;

  localparam int HOLD_CYCLES = 300;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [1:0] m_tuser;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int hold_served;

  deframe_scoreboard sb;

  sync_length_crc_deframer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // transfer monitor: inputs are noted before outputs are checked
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata);
      if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast, m_tuser);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    hold_served = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_served) begin
        hold_served++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // one byte on the input stream; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // complete frame of len+27 bytes, CRC optionally damaged
  task automatic send_frame(input int unsigned len, input crc_fault_t fault);
    logic [15:0] crc;
    logic [15:0] l16;
    logic [7:0]  b;
    logic [7:0]  lo;
    logic [7:0]  hi;
    l16 = len[15:0];
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    crc = CRC_INIT;
    crc = crc16_step(crc, l16[7:0]);
    send_byte(l16[7:0]);
    crc = crc16_step(crc, l16[15:8]);
    send_byte(l16[15:8]);
    for (int unsigned i = 0; i < len + 20; i++) begin
      b = 8'($urandom_range(255));
      crc = crc16_step(crc, b);
      send_byte(b);
    end
    lo = crc[7:0];
    hi = crc[15:8];
    if (fault == CRC_BAD_LOW || fault == CRC_BAD_BOTH) lo = lo ^ 8'($urandom_range(1, 255));
    if (fault == CRC_BAD_HIGH || fault == CRC_BAD_BOTH) hi = hi ^ 8'($urandom_range(1, 255));
    send_byte(lo);
    send_byte(hi);
    send_byte(8'($urandom_range(255)));
  endtask

  // mixed random traffic until about item_goal counted bytes went in
  task automatic random_traffic(input int item_goal);
    int          items;
    int          pick;
    int unsigned len;
    int          n;
    logic [7:0]  b;
    crc_fault_t  fault;
    items = 0;
    while (items < item_goal) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // well-formed frame, mostly short
        n = $urandom_range(99);
        if (n < 85) len = $urandom_range(0, 12);
        else if (n < 98) len = $urandom_range(13, 60);
        else len = $urandom_range(256, 300);
        if ($urandom_range(99) < 75) fault = CRC_INTACT;
        else fault = crc_fault_t'($urandom_range(1, 3));
        send_frame(len, fault);
        items += len + 27;
      end else if (pick < 80) begin
        // line noise
        n = $urandom_range(1, 6);
        repeat (n) send_byte(8'($urandom_range(255)));
      end else if (pick < 88) begin
        // false sync: abort or restart
        b = 8'($urandom_range(255));
        if (b == SYNC_SECOND) b = SYNC_FIRST;
        send_byte(SYNC_FIRST);
        send_byte(b);
        items += 2;
      end else begin
        // frame header plus random bytes, mostly truncated; the following bytes get absorbed
        len = $urandom_range(0, 8);
        n = $urandom_range(0, len + 24);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(len[7:0]);
        send_byte(8'h00);
        repeat (n) send_byte(8'($urandom_range(255)));
        items += 4 + n;
      end
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    m_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: ignored bytes, aborted sync, double restart, shortest frame
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_SECOND);
    send_byte(SYNC_FIRST);
    send_byte(8'hFF);
    send_byte(SYNC_FIRST);
    send_byte(8'h00);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_frame(0, CRC_INTACT);

    // back pressure: receiver holds off while the sender keeps going
    hold_requests <= hold_requests + 1;
    send_frame(60, CRC_INTACT);

    // random phases: none, sender idle, receiver stall, both
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct <= 71;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct <= 0;
          recv_stall_pct <= 71;
        end
        default: begin
          send_idle_pct <= 37;
          recv_stall_pct <= 37;
        end
      endcase
      // no byte on offer while the new phase settles
      s_tvalid <= 1'b0;
      @(negedge clk);
      random_traffic(500);
    end
    s_tvalid <= 1'b0;

    // drain, then wait on for stray outputs
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
